### src/tfat_pkg.sv
// Package for the file age table: opcode and status codes, field widths.
// Used by ttl_file_age_table_core. No dependencies.
`timescale 1ns / 1ps

package tfat_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int KEY_W         = 64;
    localparam int TIME_W        = 32;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;
    localparam int IN_DATA_W     = KEY_W + 2 * TIME_W;
    localparam int OUT_DATA_W    = KEY_W + TIME_W;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_AGE    = 3'd1,
        OP_MARK   = 3'd2,
        OP_RETAIN = 3'd3,
        OP_COMMIT = 3'd4,
        OP_ABORT  = 3'd5
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_REJECTED = 2'd1,
        ST_FULL     = 2'd2,
        ST_NONE     = 2'd3
    } status_t;

endpackage

### src/ttl_file_age_table_core.sv
// File age table: key/open-time store with pending marks, scanned one entry per cycle.
// Depends on tfat_pkg.
`timescale 1ns / 1ps

//  channel  | direction | signals                         | contents
//  s_axis   | in        | tvalid tready tdata tuser       | key, open/current time, ttl; opcode
//  m_axis   | out       | tvalid tready tdata tuser tlast | flagged key, max age; status; last
//
//  Add, age query, retain and a mark that flags nothing: a scan of every slot, one read of
//  the key/time memory per cycle through the single compare stage, then the finish state.
//  Commit, abort and unused codes go straight to the finish state.
//  Mark with flagged keys: the scan flags them, then the walk steps one slot per cycle up
//  to the last flagged one, and each flagged key is emitted from its own memory read.
//  Reset clears valid and pending bits at once; no clearing pass. Output stalls hold
//  the sequencer; s_axis_tready is high only between items.

module ttl_file_age_table_core
    import tfat_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [63:0] file_key, [95:64] time_sec, [127:96] ttl_sec
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [2:0] opcode
    input  logic [OP_W-1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [63:0] out_key, [95:64] max_age
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [STATUS_W-1:0]   m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_EMIT_WALK,
        S_EMIT_OUT
    } state_t;

    state_t                   state_reg;
    opcode_t                  op_reg;
    logic [KEY_W-1:0]         key_reg;
    logic [TIME_W-1:0]        time_reg;
    logic [TIME_W-1:0]        ttl_reg;

    logic [TABLE_DEPTH-1:0]   valid_reg;
    logic [TABLE_DEPTH-1:0]   pending_reg;

    logic [CW-1:0]            cnt_reg;
    logic                     rd_act_reg;
    logic [IW-1:0]            rd_idx_reg;

    logic                     match_found_reg;
    logic [IW-1:0]            match_idx_reg;
    logic                     free_found_reg;
    logic [IW-1:0]            free_idx_reg;
    logic                     any_reg;
    logic [TIME_W-1:0]        min_reg;

    logic                     out_valid_reg;
    status_t                  out_status_reg;
    logic [KEY_W-1:0]         out_key_reg;
    logic [TIME_W-1:0]        out_age_reg;
    logic                     out_last_reg;

    // key and open-time store
    logic [KEY_W-1:0]         key_mem  [TABLE_DEPTH];
    logic [TIME_W-1:0]        time_mem [TABLE_DEPTH];
    logic [KEY_W-1:0]         key_rd_reg;
    logic [TIME_W-1:0]        time_rd_reg;

    logic [IW-1:0]            cnt_idx;
    logic                     out_free;
    logic                     out_load;
    logic                     mem_we;
    logic [IW-1:0]            wr_idx;
    logic signed [TIME_W:0]   thr;
    logic                     is_old;
    logic                     entry_valid;
    logic                     entry_pending;
    logic                     scan_done;
    logic                     more_pending;
    logic [TIME_W-1:0]        age;

    assign cnt_idx   = cnt_reg[IW-1:0];
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign out_load  = out_free && (state_reg == S_FINISH || state_reg == S_EMIT_OUT);
    assign scan_done = (cnt_reg == CW'(TABLE_DEPTH)) && !rd_act_reg;

    // signed threshold, one bit wider than the time fields
    assign thr    = $signed({1'b0, time_reg}) - $signed({1'b0, ttl_reg});
    assign is_old = $signed({1'b0, time_rd_reg}) < thr;

    assign entry_valid   = valid_reg[rd_idx_reg];
    assign entry_pending = pending_reg[rd_idx_reg];

    // any flagged entry left above the one being emitted
    assign more_pending = ((pending_reg >> cnt_idx) >> 1) != '0;

    assign age = (any_reg && (time_reg > min_reg)) ? time_reg - min_reg : '0;

    assign wr_idx = match_found_reg ? match_idx_reg : free_idx_reg;
    assign mem_we = (state_reg == S_FINISH) && out_free && (op_reg == OP_ADD)
                    && ((match_found_reg && pending_reg[match_idx_reg])
                        || (!match_found_reg && free_found_reg));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[wr_idx]  <= key_reg;
            time_mem[wr_idx] <= time_reg;
        end
        key_rd_reg  <= key_mem[cnt_idx];
        time_rd_reg <= time_mem[cnt_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            valid_reg       <= '0;
            pending_reg     <= '0;
            cnt_reg         <= '0;
            rd_act_reg      <= 1'b0;
            rd_idx_reg      <= '0;
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            any_reg         <= 1'b0;
            min_reg         <= '1;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= ST_OK;
            out_key_reg     <= '0;
            out_age_reg     <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    rd_act_reg <= 1'b0;
                    if (s_axis_tvalid)
                    begin
                        cnt_reg         <= '0;
                        match_found_reg <= 1'b0;
                        free_found_reg  <= 1'b0;
                        any_reg         <= 1'b0;
                        min_reg         <= '1;
                        if (opcode_t'(s_axis_tuser) == OP_ADD
                            || opcode_t'(s_axis_tuser) == OP_AGE
                            || opcode_t'(s_axis_tuser) == OP_MARK
                            || opcode_t'(s_axis_tuser) == OP_RETAIN)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end

                S_SCAN:
                begin
                    // issue one read per cycle, compare in the next cycle
                    rd_act_reg <= (cnt_reg != CW'(TABLE_DEPTH));
                    rd_idx_reg <= cnt_idx;
                    if (cnt_reg != CW'(TABLE_DEPTH))
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end

                    if (rd_act_reg)
                    begin
                        if (entry_valid)
                        begin
                            any_reg <= 1'b1;
                            if (time_rd_reg < min_reg)
                            begin
                                min_reg <= time_rd_reg;
                            end
                            if (key_rd_reg == key_reg)
                            begin
                                match_found_reg <= 1'b1;
                                match_idx_reg   <= rd_idx_reg;
                            end
                            if (op_reg == OP_MARK && (entry_pending || is_old))
                            begin
                                pending_reg[rd_idx_reg] <= 1'b1;
                            end
                        end
                        else if (!free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= rd_idx_reg;
                        end
                    end

                    if (scan_done)
                    begin
                        cnt_reg <= '0;
                        if (op_reg == OP_MARK && pending_reg != '0)
                        begin
                            state_reg <= S_EMIT_WALK;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end

                S_EMIT_WALK:
                begin
                    if (pending_reg[cnt_idx])
                    begin
                        state_reg <= S_EMIT_OUT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end

                S_EMIT_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= ST_OK;
                        out_key_reg    <= key_rd_reg;
                        out_age_reg    <= '0;
                        out_last_reg   <= !more_pending;
                        if (more_pending)
                        begin
                            cnt_reg   <= cnt_reg + 1'b1;
                            state_reg <= S_EMIT_WALK;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end

                S_FINISH:
                begin
                    rd_act_reg <= 1'b0;
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_key_reg   <= '0;
                        out_age_reg   <= (op_reg == OP_AGE) ? age : '0;
                        out_last_reg  <= 1'b1;
                        state_reg     <= S_IDLE;
                        unique case (op_reg)
                            OP_ADD:
                            begin
                                if (match_found_reg)
                                begin
                                    if (pending_reg[match_idx_reg])
                                    begin
                                        pending_reg[match_idx_reg] <= 1'b0;
                                        out_status_reg             <= ST_OK;
                                    end
                                    else
                                    begin
                                        out_status_reg <= ST_REJECTED;
                                    end
                                end
                                else if (free_found_reg)
                                begin
                                    valid_reg[free_idx_reg]   <= 1'b1;
                                    pending_reg[free_idx_reg] <= 1'b0;
                                    out_status_reg            <= ST_OK;
                                end
                                else
                                begin
                                    out_status_reg <= ST_FULL;
                                end
                            end
                            OP_AGE:
                            begin
                                out_status_reg <= ST_OK;
                            end
                            OP_MARK:
                            begin
                                // only reached when nothing was flagged
                                out_status_reg <= ST_NONE;
                            end
                            OP_RETAIN:
                            begin
                                if (match_found_reg)
                                begin
                                    pending_reg[match_idx_reg] <= 1'b0;
                                end
                                out_status_reg <= ST_OK;
                            end
                            OP_COMMIT:
                            begin
                                valid_reg      <= valid_reg & ~pending_reg;
                                pending_reg    <= '0;
                                out_status_reg <= ST_OK;
                            end
                            OP_ABORT:
                            begin
                                pending_reg    <= '0;
                                out_status_reg <= ST_OK;
                            end
                            default:
                            begin
                                out_status_reg <= ST_OK;
                            end
                        endcase
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // item capture; payload only
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            op_reg   <= opcode_t'(s_axis_tuser);
            key_reg  <= s_axis_tdata[KEY_W-1:0];
            time_reg <= s_axis_tdata[KEY_W+TIME_W-1:KEY_W];
            ttl_reg  <= s_axis_tdata[IN_DATA_W-1:KEY_W+TIME_W];
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_age_reg, out_key_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
